// File: hdl/mavw_pkg.sv
// Shared constants and types for the moving average window block.
package mavw_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int AVG_W        = 16;
  localparam int SUM_W        = 24;
  localparam int CNT_W        = 8;
  localparam int LIMIT_CAP    = (WINDOW_DEPTH < 255) ? WINDOW_DEPTH : 255;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(16);

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hdl/mavw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mavw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/mavw_div.sv
// Restoring divider, one quotient bit per cycle, signed sum by unsigned count.
module mavw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mavw_pkg::div_req_t req,
  output mavw_pkg::div_rsp_t rsp
);

  localparam int SW = mavw_pkg::SUM_W;
  localparam int CW = mavw_pkg::CNT_W;
  localparam int DW = mavw_pkg::DIV_CNT_W;
  localparam int AW = mavw_pkg::AVG_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] q_r, q_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;

  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_diff;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[SW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_diff = rem_sh - {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DW'(SW);
      q_nxt    = req.mag;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      q_nxt   = {q_r[SW-2:0], ge};
      rem_nxt = ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (AW'(0) - q_r[AW-1:0]) : q_r[AW-1:0];

endmodule

// File: hdl/moving_average_window.sv
// Moving average window: sample store, running sum, drop sequencer and divider.
//
//   port group | dir | flow control         | payload
//   in_        | in  | in_valid / in_ready  | in_req_type, in_sample
//   out_       | out | out_valid / out_ready| out_average, out_count
//   cfg_       | in  | cfg_wr_en            | cfg_wr_data (window size)
//
// One request at a time: accept, then per dropped sample a RAM read and a
// subtract, then append, the serial divide, and loading of the output; a
// clear goes straight from accept to loading the output.
// The RAM read is registered, so each drop waits on it before the subtract.
// Reset (synchronous) empties the window and sets the window size to 16.
// A request is taken while the previous result still waits on out_ready.
module moving_average_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic signed [mavw_pkg::SAMPLE_W-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [mavw_pkg::AVG_W-1:0]    out_average,
  output logic [mavw_pkg::CNT_W-1:0]     out_count,
  input  logic                           cfg_wr_en,
  input  logic [mavw_pkg::CNT_W-1:0]     cfg_wr_data
);

  localparam int IW  = mavw_pkg::IDX_W;
  localparam int SW  = mavw_pkg::SUM_W;
  localparam int CW  = mavw_pkg::CNT_W;
  localparam int XW  = mavw_pkg::SAMPLE_W;
  localparam int AW  = mavw_pkg::AVG_W;
  localparam int PW  = ((IW > CW) ? IW : CW) + 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DROP_RD  = 3'd1;
  localparam logic [2:0] ST_DROP_SUB = 3'd2;
  localparam logic [2:0] ST_APPEND   = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_FIN      = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] window_r, window_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [IW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [XW-1:0] smp_r, smp_nxt;
  logic [AW-1:0] res_avg_r, res_avg_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_average_r, out_average_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic [CW-1:0] limit;
  logic [PW-1:0] slot_sum;
  logic [PW-1:0] slot_wrap;
  logic [IW-1:0] oldest_inc;
  logic [XW-1:0] ram_rdata;
  logic          ram_we;
  logic          ram_re;
  logic [CW-1:0] held_dec;
  logic [SW-1:0] sum_add;

  mavw_pkg::div_req_t div_req;
  mavw_pkg::div_rsp_t div_rsp;

  mavw_ram #(
    .WIDTH(XW),
    .DEPTH(mavw_pkg::WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_wrap[IW-1:0]),
    .wdata (smp_r),
    .re    (ram_re),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  mavw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign limit = (window_r > CW'(mavw_pkg::LIMIT_CAP)) ? CW'(mavw_pkg::LIMIT_CAP) : window_r;
  assign slot_sum   = PW'(oldest_r) + PW'(held_r);
  assign slot_wrap  = (slot_sum >= PW'(mavw_pkg::WINDOW_DEPTH)) ?
                      (slot_sum - PW'(mavw_pkg::WINDOW_DEPTH)) : slot_sum;
  assign oldest_inc = (oldest_r == IW'(mavw_pkg::WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign held_dec   = held_r - 1'b1;
  assign sum_add    = sum_r + {{(SW-XW){smp_r[XW-1]}}, smp_r};

  assign ram_we = (state_r == ST_APPEND);
  assign ram_re = (state_r == ST_DROP_RD);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    div_req.start   = (state_r == ST_APPEND);
    div_req.neg     = sum_add[SW-1];
    div_req.mag     = sum_add[SW-1] ? (SW'(0) - sum_add) : sum_add;
    div_req.divisor = held_r + 1'b1;
  end

  always_comb begin
    state_nxt       = state_r;
    window_nxt      = cfg_wr_en ? cfg_wr_data : window_r;
    sum_nxt         = sum_r;
    oldest_nxt      = oldest_r;
    held_nxt        = held_r;
    smp_nxt         = smp_r;
    res_avg_nxt     = res_avg_r;
    out_valid_nxt   = out_valid_r;
    out_average_nxt = out_average_r;
    out_count_nxt   = out_count_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          smp_nxt = in_sample;
          if (in_req_type == mavw_pkg::REQ_CLEAR || limit == '0) begin
            sum_nxt     = '0;
            oldest_nxt  = '0;
            held_nxt    = '0;
            res_avg_nxt = '0;
            state_nxt   = ST_FIN;
          end else if (held_r >= limit) begin
            state_nxt = ST_DROP_RD;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_DROP_RD: begin
        state_nxt = ST_DROP_SUB;
      end
      ST_DROP_SUB: begin
        sum_nxt    = sum_r - {{(SW-XW){ram_rdata[XW-1]}}, ram_rdata};
        oldest_nxt = oldest_inc;
        held_nxt   = held_dec;
        state_nxt  = (held_dec >= limit) ? ST_DROP_RD : ST_APPEND;
      end
      ST_APPEND: begin
        sum_nxt   = sum_add;
        held_nxt  = held_r + 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_avg_nxt = div_rsp.quotient;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = res_avg_r;
          out_count_nxt   = held_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= mavw_pkg::WINDOW_RESET;
      sum_r       <= '0;
      oldest_r    <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      sum_r       <= sum_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r         <= smp_nxt;
    res_avg_r     <= res_avg_nxt;
    out_average_r <= out_average_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_count   = out_count_r;

  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(mavw_pkg::LIMIT_CAP))
    else $error("held count above store limit");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && held_r == '0) |-> sum_r == '0)
    else $error("empty window with nonzero sum");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider result outside divide phase");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != ST_IDLE)
    else $error("request accepted without leaving idle");

endmodule

// File: dv/moving_average_window_tb.sv
// Testbench for moving_average_window: random traffic checked against a running average model.
`timescale 1ns / 100ps

module moving_average_window_tb;

  typedef enum int {MIX, ALL_MAX, ALL_MIN} sample_mix_t;

  localparam logic signed [mavw_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [mavw_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;

  class avg_scoreboard_t;
    logic signed [mavw_pkg::SAMPLE_W-1:0] samples [mavw_pkg::WINDOW_DEPTH];
    int window_sz;
    int sum;
    int oldest;
    int held;
    logic signed [mavw_pkg::AVG_W-1:0] avg_due [$];
    logic [mavw_pkg::CNT_W-1:0] count_due [$];
    int errors;
    int checked;
    int pushes;
    int clears;

    function new();
      window_sz = mavw_pkg::WINDOW_RESET;
      sum = 0;
      oldest = 0;
      held = 0;
      errors = 0;
      checked = 0;
      pushes = 0;
      clears = 0;
    endfunction

    function void set_window(int v);
      window_sz = v;
    endfunction

    function int pending();
      return avg_due.size();
    endfunction

    function void note_request(logic req, logic signed [mavw_pkg::SAMPLE_W-1:0] smp);
      int limit;
      limit = (window_sz > mavw_pkg::WINDOW_DEPTH) ? mavw_pkg::WINDOW_DEPTH : window_sz;
      if (req == mavw_pkg::REQ_CLEAR) begin
        clears++;
      end else begin
        pushes++;
      end
      if (req == mavw_pkg::REQ_CLEAR || limit == 0) begin
        sum = 0;
        oldest = 0;
        held = 0;
      end else begin
        while (held >= limit) begin
          sum -= samples[oldest];
          oldest = (oldest + 1) % mavw_pkg::WINDOW_DEPTH;
          held--;
        end
        samples[(oldest + held) % mavw_pkg::WINDOW_DEPTH] = smp;
        sum += smp;
        held++;
      end
      avg_due.push_back((held != 0) ? mavw_pkg::AVG_W'(sum / held) : '0);
      count_due.push_back(mavw_pkg::CNT_W'(held));
    endfunction

    function void check_result(logic signed [mavw_pkg::AVG_W-1:0] avg,
                               logic [mavw_pkg::CNT_W-1:0] cnt);
      logic signed [mavw_pkg::AVG_W-1:0] want_avg;
      logic [mavw_pkg::CNT_W-1:0] want_cnt;
      if (avg_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result with no request pending: average %0d count %0d",
                   $realtime, avg, cnt);
        end
        return;
      end
      want_avg = avg_due.pop_front();
      want_cnt = count_due.pop_front();
      checked++;
      if (avg !== want_avg || cnt !== want_cnt) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch: average exp %0d got %0d, count exp %0d got %0d",
                   $realtime, want_avg, avg, want_cnt, cnt);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_req_type = mavw_pkg::REQ_PUSH;
  logic signed [mavw_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [mavw_pkg::CNT_W-1:0] cfg_wr_data = '0;
  logic in_ready;
  logic out_valid;
  logic signed [mavw_pkg::AVG_W-1:0] out_average;
  logic [mavw_pkg::CNT_W-1:0] out_count;

  avg_scoreboard_t sb = new();
  int burst_left = 0;
  bit src_idle = 1'b1;
  int settings_seen = 0;
  logic [31:0] rdy_pat = '1;
  int rdy_age = 0;

  moving_average_window dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .out_count   (out_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("moving_average_window_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_req_type, in_sample);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_average, out_count);
    end
  end

  // hold the ready pattern for a while, then pick a new one
  always @(posedge clk) begin
    if (rdy_age == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        rdy_pat <= '1;
      end else if ($urandom_range(0, 1) == 0) begin
        rdy_pat <= $urandom | 32'h1;
      end else begin
        rdy_pat <= ($urandom & $urandom & $urandom) | 32'h1;
      end
      rdy_age <= $urandom_range(50, 400);
      out_ready <= 1'b1;
    end else begin
      rdy_pat <= {rdy_pat[0], rdy_pat[31:1]};
      rdy_age <= rdy_age - 1;
      out_ready <= rdy_pat[0];
    end
  end

  function automatic logic signed [mavw_pkg::SAMPLE_W-1:0] pick_sample(sample_mix_t mix);
    int r;
    r = $urandom_range(0, 9);
    if (mix == ALL_MAX) begin
      return S_MAX;
    end else if (mix == ALL_MIN) begin
      return S_MIN;
    end else if (r == 0) begin
      return S_MAX;
    end else if (r == 1) begin
      return S_MIN;
    end else if (r < 4) begin
      return mavw_pkg::SAMPLE_W'($urandom_range(0, 200) - 100);
    end
    return mavw_pkg::SAMPLE_W'($urandom);
  endfunction

  task automatic send_req(input logic req, input logic signed [mavw_pkg::SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      if (src_idle) begin
        gap = $urandom_range(1, 40);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_window(input int v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mavw_pkg::CNT_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(v);
    settings_seen++;
  endtask

  task automatic run_phase(input int win, input int n, input int clear_pct,
                           input sample_mix_t mix);
    logic req;
    set_window(win);
    src_idle = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      req = ($urandom_range(0, 99) < clear_pct) ? mavw_pkg::REQ_CLEAR : mavw_pkg::REQ_PUSH;
      send_req(req, pick_sample(mix));
      if (i == n / 2 && $urandom_range(0, 2) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    int win;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(mavw_pkg::REQ_CLEAR, S_MAX);
    repeat (3) send_req(mavw_pkg::REQ_PUSH, S_MAX);
    repeat (4) send_req(mavw_pkg::REQ_PUSH, S_MIN);
    send_req(mavw_pkg::REQ_CLEAR, '0);
    send_req(mavw_pkg::REQ_PUSH, -16'sd3);
    send_req(mavw_pkg::REQ_PUSH, 16'sd2);
    send_req(mavw_pkg::REQ_PUSH, -16'sd4);
    send_req(mavw_pkg::REQ_PUSH, 16'sh5555);
    send_req(mavw_pkg::REQ_PUSH, 16'shAAAA);
    send_req(mavw_pkg::REQ_PUSH, 16'sd1);
    send_req(mavw_pkg::REQ_CLEAR, '0);
    send_req(mavw_pkg::REQ_PUSH, '0);
    send_req(mavw_pkg::REQ_CLEAR, S_MIN);

    // window of zero: every push leaves the window empty
    set_window(0);
    send_req(mavw_pkg::REQ_PUSH, S_MAX);
    send_req(mavw_pkg::REQ_PUSH, S_MIN);
    send_req(mavw_pkg::REQ_CLEAR, '0);
    send_req(mavw_pkg::REQ_PUSH, -16'sd1);

    run_phase(255, 260, 0, ALL_MIN);
    run_phase(255, 260, 0, ALL_MAX);
    run_phase(1, 60, 5, MIX);
    run_phase(255, 300, 1, MIX);
    run_phase(2, 100, 5, MIX);
    run_phase(255, 260, 0, MIX);
    run_phase(3, 100, 5, MIX);
    run_phase(0, 20, 10, MIX);
    for (int p = 0; p < 6; p++) begin
      win = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 24);
      run_phase(win, $urandom_range(40, 80), 4, MIX);
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected results never arrived", sb.pending());
    end
    $display("%0d pushes and %0d clears sent, %0d results checked",
             sb.pushes, sb.clears, sb.checked);
    $display("%0d window size writes, sizes 0 through 255, shrink after full window",
             settings_seen);
    if (sb.errors == 0) begin
      $display("moving_average_window_tb: clean");
    end else begin
      $display("moving_average_window_tb: errors");
    end
    $finish;
  end

endmodule

// File: moving_average_window.f
hdl/mavw_pkg.sv
hdl/mavw_ram.sv
hdl/mavw_div.sv
hdl/moving_average_window.sv
dv/moving_average_window_tb.sv
